[design/sppr_pkg.sv]
// Shared types and constants for the sub-pixel peak refinement block.
// No dependencies; every other file of the block uses this package.
package sppr_pkg;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;

	localparam int CW       = 12;	// coordinate width, covers col + reach
	localparam int DIM_W    = 8;
	localparam int COORD_W  = 7;
	localparam int SMP_W    = 32;
	localparam int TOL_W    = 16;
	localparam int XY_W     = 15;
	localparam int STAT_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DIFF_W = SMP_W + 1;
	localparam int TERM_W = 42;	// a * diff
	localparam int DIST_W = 8;
	localparam int PROD_W = TERM_W + DIST_W + 1;
	localparam int NUM_W  = PROD_W + 1;
	localparam int DEN_W  = TERM_W + 1;
	localparam int DIV_NW = 60;
	localparam int DIV_DW = DEN_W + 1;
	localparam int V_W    = DIV_NW + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH  = 2'd0,
		REG_MAP_HEIGHT = 2'd1,
		REG_TOLERANCE  = 2'd2,
		REG_BYPASS     = 2'd3
	} sppr_reg_t;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} sppr_func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_ROOM = 2'd1,
		STAT_FLAT = 2'd2
	} sppr_stat_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} sppr_dir_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_SADR,
		ST_SCMP,
		ST_VM0,
		ST_VM1,
		ST_VM2,
		ST_VM3,
		ST_VCHK,
		ST_VDIV,
		ST_DONE
	} sppr_state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] n;
		logic [DIV_DW-1:0] d;
	} sppr_div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_NW-1:0] q;
	} sppr_div_rsp_t;

endpackage

[design/sppr_in_if.sv]
// Input item channel: load samples and queries.
// Depends on sppr_pkg for field widths.
interface sppr_in_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [sppr_pkg::COORD_W-1:0]  col;
	logic [sppr_pkg::COORD_W-1:0]  row;
	logic signed [sppr_pkg::SMP_W-1:0] sample;

	modport source (output valid, func, col, row, sample, input ready);
	modport sink   (input valid, func, col, row, sample, output ready);
endinterface

[design/sppr_out_if.sv]
// Result channel: refined peak location and status.
// Depends on sppr_pkg for field widths.
interface sppr_out_if;
	logic                         valid;
	logic                         ready;
	logic [sppr_pkg::XY_W-1:0]    peak_x;
	logic [sppr_pkg::XY_W-1:0]    peak_y;
	logic [sppr_pkg::STAT_W-1:0]  status;

	modport source (output valid, peak_x, peak_y, status, input ready);
	modport sink   (input valid, peak_x, peak_y, status, output ready);
endinterface

[design/sppr_cfg_if.sv]
// Configuration write channel: register index and write data.
// Depends on sppr_pkg for field widths.
interface sppr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sppr_pkg::CFG_IDX_W-1:0]   index;
	logic [sppr_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[design/sppr_map.sv]
// Heat-map sample store: one write port, one registered read port.
// Depends on sppr_pkg for the sample width.
module sppr_map #(
	parameter int DEPTH = sppr_pkg::DEF_MAX_WIDTH * sppr_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(DEPTH)-1:0]          waddr,
	input  logic signed [sppr_pkg::SMP_W-1:0] wdata,
	input  logic [$clog2(DEPTH)-1:0]          raddr,
	output logic signed [sppr_pkg::SMP_W-1:0] rdata
);
	logic signed [sppr_pkg::SMP_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/sppr_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on sppr_pkg for widths and the request/response structs.
module sppr_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sppr_pkg::sppr_div_req_t req,
	output sppr_pkg::sppr_div_rsp_t rsp
);
	localparam int NW  = sppr_pkg::DIV_NW;
	localparam int DW  = sppr_pkg::DIV_DW;
	localparam int CNW = $clog2(NW + 1);

	logic [NW-1:0]  quo_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  d_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DW:0]    r_sh;
	logic [DW:0]    r_sub;

	assign r_sh  = {rem_q, quo_q[NW-1]};
	assign r_sub = r_sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			quo_q <= req.n;
			rem_q <= '0;
			d_q   <= req.d;
		end else if (busy_q) begin
			if (!r_sub[DW]) begin
				rem_q <= r_sub[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= r_sh[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.q    = quo_q;
endmodule

[design/subpixel_peak_parabola_refine.sv]
// Top level of the sub-pixel peak refinement block: sequencer, shared
// multiplier, map store and divider. Depends on sppr_pkg, the three
// channel interfaces, sppr_map and sppr_div.
//
// Usage:
//   item   : load (func 0) writes one sample at (col, row); query (func 1)
//            refines the peak starting at (col, row) and gives one result.
//   result : peak_x, peak_y in Q8, and status. Held until taken.
//   cfg    : register writes, always ready; write only while idle.
// Sequence: loads are taken back to back while idle. A query reads its
//   start sample, then takes an address and a compare step per scan step
//   (four scans of at most size/16 steps each, one map read port), then
//   per axis the multiply/accumulate states VM0 to VM3, a check and the
//   bit-serial divider (60 bits, skipped on a zero denominator), and then
//   posts the result. Early exits (bypass, start off map, scan out of room)
//   go straight to the final state. item.ready is low for the whole query.
// Reset: control state and registers return to defaults; the map keeps
//   its contents undefined and needs no clearing.
// Stall: a finished query waits in its last state while an earlier result
//   is still held; loads may still be taken while only the result waits.
module subpixel_peak_parabola_refine #(
	parameter int MAX_WIDTH  = sppr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sppr_pkg::DEF_MAX_HEIGHT
) (
	input  logic    clk,
	input  logic    arst_n,
	sppr_in_if.sink   item,
	sppr_out_if.source result,
	sppr_cfg_if.sink  cfg
);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = sppr_pkg::CW;
	localparam int SW    = sppr_pkg::SMP_W;

	function automatic logic signed [sppr_pkg::DIFF_W-1:0] DIFF_W_EXT(
		input logic signed [SW-1:0] v);
		return sppr_pkg::DIFF_W'(v);
	endfunction

	sppr_pkg::sppr_state_t state_q, state_d;

	// configuration
	logic [sppr_pkg::DIM_W-1:0] wreg_q, hreg_q;
	logic [sppr_pkg::TOL_W-1:0] tol_q;
	logic                       bypass_q;

	// query context
	logic [CW-1:0] col_q, row_q, xlo_q, xhi_q, ylo_q, yhi_q, p_q;
	logic signed [SW-1:0] start_q;
	sppr_pkg::sppr_dir_t  dir_q;
	logic [CW-1:0]        stop_q [4];
	logic signed [SW-1:0] ys_q [4];
	logic                 axis_q;
	logic                 flag_q;
	logic                 neg_q;

	logic signed [sppr_pkg::TERM_W-1:0] t_q;
	logic signed [sppr_pkg::NUM_W-1:0]  num_q;
	logic signed [sppr_pkg::DEN_W-1:0]  den_q;

	logic [sppr_pkg::XY_W-1:0]   px_q, py_q;
	logic [sppr_pkg::STAT_W-1:0] st_q;

	logic                        ov_q;
	logic [sppr_pkg::XY_W-1:0]   ox_q, oy_q;
	logic [sppr_pkg::STAT_W-1:0] os_q;

	// ---------------- input decode ----------------
	logic item_acc, query_acc, load_acc, off_map;
	logic [CW-1:0] w_eff, h_eff, mxr, myr, icol, irow;

	assign item.ready = (state_q == sppr_pkg::ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign query_acc  = item_acc && (item.func == sppr_pkg::FUNC_QUERY);
	assign load_acc   = item_acc && (item.func == sppr_pkg::FUNC_LOAD);

	assign icol  = CW'(item.col);
	assign irow  = CW'(item.row);
	assign w_eff = (wreg_q == '0) ? CW'(1) :
		((CW'(wreg_q) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(wreg_q));
	assign h_eff = (hreg_q == '0) ? CW'(1) :
		((CW'(hreg_q) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(hreg_q));
	assign mxr     = w_eff >> 4;
	assign myr     = h_eff >> 4;
	assign off_map = (icol >= w_eff) || (irow >= h_eff);

	// ---------------- map store ----------------
	logic          map_we;
	logic [AW-1:0] map_waddr, map_raddr;
	logic signed [SW-1:0] map_rdata;
	logic [CW-1:0] rx, ry;

	assign map_we = load_acc && (int'(item.col) < MAX_WIDTH)
		&& (int'(item.row) < MAX_HEIGHT);
	assign map_waddr = AW'(int'(item.row) * MAX_WIDTH + int'(item.col));
	assign map_raddr = AW'(int'(ry) * MAX_WIDTH + int'(rx));

	sppr_map #(.DEPTH(DEPTH)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (item.sample),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// ---------------- scan step ----------------
	logic          horiz, at_edge, stop_hit;
	logic [CW-1:0] pn;
	logic signed [sppr_pkg::DIFF_W-1:0] sdiff;
	logic [sppr_pkg::DIFF_W-1:0]        sabs;

	assign horiz = (dir_q == sppr_pkg::DIR_RIGHT) || (dir_q == sppr_pkg::DIR_LEFT);
	assign pn = ((dir_q == sppr_pkg::DIR_RIGHT) || (dir_q == sppr_pkg::DIR_UP)) ?
		p_q + 1'b1 : p_q - 1'b1;

	always_comb begin
		unique case (dir_q)
			sppr_pkg::DIR_RIGHT: at_edge = (p_q == xhi_q);
			sppr_pkg::DIR_LEFT:  at_edge = (p_q == xlo_q);
			sppr_pkg::DIR_UP:    at_edge = (p_q == yhi_q);
			default:             at_edge = (p_q == ylo_q);
		endcase
	end

	assign sdiff    = DIFF_W_EXT(map_rdata) - DIFF_W_EXT(start_q);
	assign sabs     = sdiff[sppr_pkg::DIFF_W-1] ? -sdiff : sdiff;
	assign stop_hit = sabs > sppr_pkg::DIFF_W'(tol_q);

	// ---------------- vertex arithmetic ----------------
	logic [CW-1:0] v_lo, v_hi, v_c;
	logic signed [SW-1:0] v_yl, v_yr;
	logic [sppr_pkg::DIST_W-1:0] va, vb, mul_y;
	logic signed [sppr_pkg::DIFF_W-1:0] dr, dl;
	logic signed [sppr_pkg::TERM_W-1:0] mul_x;
	logic signed [sppr_pkg::PROD_W-1:0] prod;

	assign v_lo = axis_q ? stop_q[sppr_pkg::DIR_DOWN] : stop_q[sppr_pkg::DIR_LEFT];
	assign v_hi = axis_q ? stop_q[sppr_pkg::DIR_UP]   : stop_q[sppr_pkg::DIR_RIGHT];
	assign v_c  = axis_q ? row_q : col_q;
	assign v_yl = axis_q ? ys_q[sppr_pkg::DIR_DOWN] : ys_q[sppr_pkg::DIR_LEFT];
	assign v_yr = axis_q ? ys_q[sppr_pkg::DIR_UP]   : ys_q[sppr_pkg::DIR_RIGHT];
	assign va   = sppr_pkg::DIST_W'(v_c - v_lo);
	assign vb   = sppr_pkg::DIST_W'(v_hi - v_c);
	assign dr   = DIFF_W_EXT(start_q) - DIFF_W_EXT(v_yr);
	assign dl   = DIFF_W_EXT(start_q) - DIFF_W_EXT(v_yl);

	// one shared multiplier
	always_comb begin
		unique case (state_q)
			sppr_pkg::ST_VM0: mul_x = sppr_pkg::TERM_W'(dr);
			sppr_pkg::ST_VM2: mul_x = sppr_pkg::TERM_W'(dl);
			default:          mul_x = t_q;
		endcase
		mul_y = ((state_q == sppr_pkg::ST_VM0) || (state_q == sppr_pkg::ST_VM1)) ?
			va : vb;
	end
	assign prod = mul_x * $signed({1'b0, mul_y});

	// divider request and vertex result
	sppr_pkg::sppr_div_req_t div_req;
	sppr_pkg::sppr_div_rsp_t div_rsp;
	logic [sppr_pkg::NUM_W-1:0] absn;
	logic [sppr_pkg::DEN_W-1:0] absd;
	logic signed [sppr_pkg::V_W-1:0] c256, lo256, hi256, qs, vraw;
	logic          vclip_lo, vclip_hi;
	logic [sppr_pkg::XY_W-1:0] vres;

	assign absn = num_q[sppr_pkg::NUM_W-1] ? -num_q : num_q;
	assign absd = den_q[sppr_pkg::DEN_W-1] ? -den_q : den_q;
	assign div_req.start = (state_q == sppr_pkg::ST_VCHK) && (den_q != '0);
	assign div_req.n = (sppr_pkg::DIV_NW'(absn) << 8) + sppr_pkg::DIV_NW'(absd);
	assign div_req.d = {absd, 1'b0};

	sppr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign c256  = $signed(sppr_pkg::V_W'(v_c) << 8);
	assign lo256 = $signed(sppr_pkg::V_W'(v_lo) << 8);
	assign hi256 = $signed(sppr_pkg::V_W'(v_hi) << 8);
	assign qs    = $signed(sppr_pkg::V_W'(div_rsp.q));
	assign vraw  = neg_q ? c256 + qs : c256 - qs;
	assign vclip_lo = vraw < lo256;
	assign vclip_hi = vraw > hi256;
	assign vres = vclip_lo ? lo256[sppr_pkg::XY_W-1:0] :
		(vclip_hi ? hi256[sppr_pkg::XY_W-1:0] : vraw[sppr_pkg::XY_W-1:0]);

	logic out_free;
	assign out_free = !ov_q || result.ready;

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sppr_pkg::ST_IDLE:
				if (query_acc) begin
					state_d = (bypass_q || off_map) ? sppr_pkg::ST_DONE : sppr_pkg::ST_START;
				end
			sppr_pkg::ST_START: state_d = sppr_pkg::ST_SADR;
			sppr_pkg::ST_SADR:
				state_d = at_edge ? sppr_pkg::ST_DONE : sppr_pkg::ST_SCMP;
			sppr_pkg::ST_SCMP:
				if (stop_hit && (dir_q == sppr_pkg::DIR_DOWN)) begin
					state_d = sppr_pkg::ST_VM0;
				end else begin
					state_d = sppr_pkg::ST_SADR;
				end
			sppr_pkg::ST_VM0: state_d = sppr_pkg::ST_VM1;
			sppr_pkg::ST_VM1: state_d = sppr_pkg::ST_VM2;
			sppr_pkg::ST_VM2: state_d = sppr_pkg::ST_VM3;
			sppr_pkg::ST_VM3: state_d = sppr_pkg::ST_VCHK;
			sppr_pkg::ST_VCHK:
				if (den_q != '0) begin
					state_d = sppr_pkg::ST_VDIV;
				end else begin
					state_d = axis_q ? sppr_pkg::ST_DONE : sppr_pkg::ST_VM0;
				end
			sppr_pkg::ST_VDIV:
				if (div_rsp.done) begin
					state_d = axis_q ? sppr_pkg::ST_DONE : sppr_pkg::ST_VM0;
				end
			sppr_pkg::ST_DONE:
				if (out_free) begin
					state_d = sppr_pkg::ST_IDLE;
				end
			default: state_d = sppr_pkg::ST_IDLE;
		endcase
	end

	// ---------------- read address ----------------
	always_comb begin
		if (state_q == sppr_pkg::ST_IDLE) begin
			rx = icol;
			ry = irow;
		end else if (horiz) begin
			rx = pn;
			ry = row_q;
		end else begin
			rx = col_q;
			ry = pn;
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sppr_pkg::ST_IDLE;
			ov_q     <= 1'b0;
			wreg_q   <= 8'd128;
			hreg_q   <= 8'd128;
			tol_q    <= 16'd1;
			bypass_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				unique case (sppr_pkg::sppr_reg_t'(cfg.index))
					sppr_pkg::REG_MAP_WIDTH:  wreg_q   <= cfg.data[sppr_pkg::DIM_W-1:0];
					sppr_pkg::REG_MAP_HEIGHT: hreg_q   <= cfg.data[sppr_pkg::DIM_W-1:0];
					sppr_pkg::REG_TOLERANCE:  tol_q    <= cfg.data;
					sppr_pkg::REG_BYPASS:     bypass_q <= cfg.data[0];
					default: ;
				endcase
			end
			if ((state_q == sppr_pkg::ST_DONE) && out_free) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign cfg.ready = 1'b1;

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			sppr_pkg::ST_IDLE:
				if (query_acc) begin
					col_q  <= icol;
					row_q  <= irow;
					xlo_q  <= (icol > mxr) ? icol - mxr : '0;
					xhi_q  <= (icol + mxr > w_eff - 1'b1) ? w_eff - 1'b1 : icol + mxr;
					ylo_q  <= (irow > myr) ? irow - myr : '0;
					yhi_q  <= (irow + myr > h_eff - 1'b1) ? h_eff - 1'b1 : irow + myr;
					p_q    <= icol;
					dir_q  <= sppr_pkg::DIR_RIGHT;
					axis_q <= 1'b0;
					flag_q <= 1'b0;
					px_q   <= {item.col, 8'd0};
					py_q   <= {item.row, 8'd0};
					st_q   <= bypass_q ? sppr_pkg::STAT_OK : sppr_pkg::STAT_ROOM;
				end
			sppr_pkg::ST_START: start_q <= map_rdata;
			sppr_pkg::ST_SADR:  p_q <= pn;
			sppr_pkg::ST_SCMP:
				if (stop_hit) begin
					stop_q[dir_q] <= p_q;
					ys_q[dir_q]   <= map_rdata;
					dir_q <= sppr_pkg::sppr_dir_t'(dir_q + 1'b1);
					p_q   <= (dir_q == sppr_pkg::DIR_RIGHT) ? col_q : row_q;
				end
			sppr_pkg::ST_VM0: t_q <= sppr_pkg::TERM_W'(prod);
			sppr_pkg::ST_VM1: begin
				num_q <= sppr_pkg::NUM_W'(prod);
				den_q <= sppr_pkg::DEN_W'(t_q);
			end
			sppr_pkg::ST_VM2: t_q <= sppr_pkg::TERM_W'(prod);
			sppr_pkg::ST_VM3: begin
				num_q <= num_q - sppr_pkg::NUM_W'(prod);
				den_q <= den_q + sppr_pkg::DEN_W'(t_q);
			end
			sppr_pkg::ST_VCHK: begin
				neg_q <= num_q[sppr_pkg::NUM_W-1] != den_q[sppr_pkg::DEN_W-1];
				if (den_q == '0) begin
					flag_q <= 1'b1;
					if (axis_q) begin
						py_q <= c256[sppr_pkg::XY_W-1:0];
						st_q <= sppr_pkg::STAT_FLAT;
					end else begin
						px_q <= c256[sppr_pkg::XY_W-1:0];
						axis_q <= 1'b1;
					end
				end
			end
			sppr_pkg::ST_VDIV:
				if (div_rsp.done) begin
					if (axis_q) begin
						py_q <= vres;
						st_q <= (flag_q || vclip_lo || vclip_hi) ?
							sppr_pkg::STAT_FLAT : sppr_pkg::STAT_OK;
					end else begin
						px_q   <= vres;
						axis_q <= 1'b1;
						flag_q <= flag_q || vclip_lo || vclip_hi;
					end
				end
			sppr_pkg::ST_DONE:
				if (out_free) begin
					ox_q <= px_q;
					oy_q <= py_q;
					os_q <= st_q;
				end
			default: ;
		endcase
	end

	assign result.valid  = ov_q;
	assign result.peak_x = ox_q;
	assign result.peak_y = oy_q;
	assign result.status = os_q;

	// ---------------- assertions ----------------
	a_query_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> !item.ready)
		else $error("item taken right after a query");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == sppr_pkg::ST_DONE))
		else $error("result posted outside the final state");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.status != 2'd3))
		else $error("undefined status code");
endmodule

[sim/subpixel_peak_parabola_refine_tb.sv]
// Testbench for subpixel_peak_parabola_refine: random and directed map loads
// and peak queries, checked against an in-bench predictor of the parabola fit.
// Depends on sppr_pkg, the three channel interfaces and the block itself.
module subpixel_peak_parabola_refine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_W     = sppr_pkg::DEF_MAX_WIDTH;
	localparam int MAP_H     = sppr_pkg::DEF_MAX_HEIGHT;
	localparam int HOLD_LEN  = 400;
	localparam int DRAIN_GAP = 20;
	localparam int END_GAP   = 300;
	localparam int CYCLE_MAX = 800000;

	typedef struct {
		sppr_pkg::sppr_func_t func;
		bit [sppr_pkg::COORD_W-1:0] col;
		bit [sppr_pkg::COORD_W-1:0] row;
		bit [sppr_pkg::SMP_W-1:0] sample;
	} map_item_t;

	typedef struct {
		bit [sppr_pkg::XY_W-1:0] x;
		bit [sppr_pkg::XY_W-1:0] y;
		sppr_pkg::sppr_stat_t st;
	} peak_t;

	typedef enum int {SCAN_ROOM, SCAN_HIT, SCAN_HOLE} scan_res_t;

	logic clk;
	logic arst_n;

	sppr_in_if  in_ch();
	sppr_out_if out_ch();
	sppr_cfg_if cfg_ch();

	subpixel_peak_parabola_refine dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(in_ch),
		.result(out_ch),
		.cfg(cfg_ch)
	);

	map_item_t pending_items[$];
	peak_t peak_exp_q[$];

	// predictor state
	int map_val[MAP_W*MAP_H];
	bit map_set[MAP_W*MAP_H];
	int cur_w = 128, cur_h = 128, cur_tol = 1;
	bit cur_byp = 0;
	int hole_x, hole_y;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0, hold_seen = 0, hold_left = 0;
	bit in_taken = 0;
	int errors = 0;
	int cycles = 0;
	int items_made = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", field, got, want, cycles);
		errors++;
	endtask

	function automatic bit peek(int x, int y, output longint v);
		v = 0;
		if (!map_set[y*MAP_W+x]) begin
			hole_x = x;
			hole_y = y;
			return 0;
		end
		v = map_val[y*MAP_W+x];
		return 1;
	endfunction

	function automatic scan_res_t scan_dir(int c, int r, int dx, int dy, int lo, int hi,
			longint base, output int stop);
		int p;
		longint v, d;
		p = (dx != 0) ? c : r;
		stop = 0;
		forever begin
			p += (dx != 0) ? dx : dy;
			if (p < lo || p > hi)
				return SCAN_ROOM;
			if (!peek((dx != 0) ? p : c, (dx != 0) ? r : p, v))
				return SCAN_HOLE;
			d = v - base;
			if (d < 0)
				d = -d;
			if (d > cur_tol) begin
				stop = p;
				return SCAN_HIT;
			end
		end
	endfunction

	function automatic longint fit_axis(longint lo, longint c, longint hi,
			longint yl, longint yc, longint yr, inout bit flag);
		longint a, b, num, den, n, dd, q, v;
		a = c - lo;
		b = hi - c;
		num = a*a*(yc - yr) - b*b*(yc - yl);
		den = a*(yc - yr) + b*(yc - yl);
		if (den == 0) begin
			flag = 1;
			return c * 256;
		end
		n = (num < 0 ? -num : num) * 256;
		dd = den < 0 ? -den : den;
		q = (n + dd) / (2 * dd);
		v = ((num < 0) != (den < 0)) ? c*256 + q : c*256 - q;
		if (v < lo*256) begin
			v = lo*256;
			flag = 1;
		end
		if (v > hi*256) begin
			v = hi*256;
			flag = 1;
		end
		return v;
	endfunction

	// Returns 0 when the query would read an unwritten cell (left in hole_x/y).
	function automatic bit predict_peak(int c, int r, output peak_t e);
		int w, h, mx, my, xlo, xhi, ylo, yhi, rt, lf, up, dn;
		longint base, vl, vr, vu, vd, px, py;
		scan_res_t sr;
		bit flag;
		flag = 0;
		e.x = sppr_pkg::XY_W'(c << 8);
		e.y = sppr_pkg::XY_W'(r << 8);
		e.st = sppr_pkg::STAT_OK;
		if (cur_byp)
			return 1;
		w = cur_w == 0 ? 1 : (cur_w > MAP_W ? MAP_W : cur_w);
		h = cur_h == 0 ? 1 : (cur_h > MAP_H ? MAP_H : cur_h);
		e.st = sppr_pkg::STAT_ROOM;
		if (c >= w || r >= h)
			return 1;
		mx = w >> 4;
		my = h >> 4;
		xlo = c - mx < 0 ? 0 : c - mx;
		xhi = c + mx > w - 1 ? w - 1 : c + mx;
		ylo = r - my < 0 ? 0 : r - my;
		yhi = r + my > h - 1 ? h - 1 : r + my;
		if (!peek(c, r, base))
			return 0;
		sr = scan_dir(c, r, 1, 0, xlo, xhi, base, rt);
		if (sr != SCAN_HIT)
			return sr == SCAN_ROOM;
		sr = scan_dir(c, r, -1, 0, xlo, xhi, base, lf);
		if (sr != SCAN_HIT)
			return sr == SCAN_ROOM;
		sr = scan_dir(c, r, 0, 1, ylo, yhi, base, up);
		if (sr != SCAN_HIT)
			return sr == SCAN_ROOM;
		sr = scan_dir(c, r, 0, -1, ylo, yhi, base, dn);
		if (sr != SCAN_HIT)
			return sr == SCAN_ROOM;
		void'(peek(lf, r, vl));
		void'(peek(rt, r, vr));
		void'(peek(c, up, vu));
		void'(peek(c, dn, vd));
		px = fit_axis(lf, c, rt, vl, base, vr, flag);
		py = fit_axis(dn, r, up, vd, base, vu, flag);
		e.x = sppr_pkg::XY_W'(px);
		e.y = sppr_pkg::XY_W'(py);
		e.st = flag ? sppr_pkg::STAT_FLAT : sppr_pkg::STAT_OK;
		return 1;
	endfunction

	task automatic add_load(int c, int r, bit [31:0] v);
		map_item_t it;
		it.func = sppr_pkg::FUNC_LOAD;
		it.col = sppr_pkg::COORD_W'(c);
		it.row = sppr_pkg::COORD_W'(r);
		it.sample = v;
		pending_items = {pending_items, it};
		map_val[r*MAP_W+c] = int'(v);
		map_set[r*MAP_W+c] = 1;
		items_made++;
	endtask

	function automatic bit [31:0] near_value(bit [31:0] base);
		case ($urandom_range(9))
			0, 1, 2: return base;
			3:       return $urandom;
			4:       return base + $urandom_range(0, 1 << 20);
			default: return base - $urandom_range(0, 1 << 20);
		endcase
	endfunction

	// Fills any cell the query would read before it, so no read hits an unwritten cell.
	task automatic add_query(int c, int r);
		map_item_t it;
		peak_t e;
		bit [31:0] base;
		while (!predict_peak(c, r, e)) begin
			base = map_set[r*MAP_W+c] ? map_val[r*MAP_W+c] : $urandom;
			add_load(hole_x, hole_y, (hole_x == c && hole_y == r) ? base : near_value(base));
		end
		it.func = sppr_pkg::FUNC_QUERY;
		it.col = sppr_pkg::COORD_W'(c);
		it.row = sppr_pkg::COORD_W'(r);
		it.sample = $urandom;
		pending_items = {pending_items, it};
		peak_exp_q = {peak_exp_q, e};
		items_made++;
	endtask

	// Peak patch along both axes around a center, then one or two queries near it.
	task automatic add_scene();
		int w, h, cx, cy, rad, x, y, k, nq;
		bit [31:0] pk;
		w = cur_w == 0 ? 1 : (cur_w > MAP_W ? MAP_W : cur_w);
		h = cur_h == 0 ? 1 : (cur_h > MAP_H ? MAP_H : cur_h);
		cx = $urandom_range(9) < 8 ? $urandom_range(0, w - 1) : $urandom_range(0, MAP_W - 1);
		cy = $urandom_range(9) < 8 ? $urandom_range(0, h - 1) : $urandom_range(0, MAP_H - 1);
		pk = $urandom;
		k = $urandom_range(1, 1 << 20);
		rad = $urandom_range(1, 3);
		for (int d = -rad; d <= rad; d++) begin
			x = cx + d;
			y = cy + d;
			if (x >= 0 && x < MAP_W)
				add_load(x, cy, ($urandom_range(3) == 0 && d != 0) ? pk
					: pk - k*d*d + $urandom_range(0, 3));
			if (d != 0 && y >= 0 && y < MAP_H)
				add_load(cx, y, ($urandom_range(3) == 0) ? pk
					: pk - k*d*d + $urandom_range(0, 3));
		end
		nq = $urandom_range(1, 2);
		for (int i = 0; i < nq; i++) begin
			x = cx + ($urandom_range(2) == 0 ? int'($urandom_range(0, 2)) - 1 : 0);
			y = cy + ($urandom_range(2) == 0 ? int'($urandom_range(0, 2)) - 1 : 0);
			if (x < 0) x = 0;
			if (y < 0) y = 0;
			if (x >= MAP_W) x = MAP_W - 1;
			if (y >= MAP_H) y = MAP_H - 1;
			add_query(x, y);
		end
	endtask

	task automatic add_random_traffic(int budget);
		int stop_at;
		stop_at = items_made + budget;
		while (items_made < stop_at) begin
			case ($urandom_range(9))
				0, 1:    add_load($urandom_range(0, MAP_W - 1), $urandom_range(0, MAP_H - 1),
						$urandom);
				2:       add_query($urandom_range(0, MAP_W - 1), $urandom_range(0, MAP_H - 1));
				default: add_scene();
			endcase
		end
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || peak_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(sppr_pkg::sppr_reg_t idx, bit [15:0] d);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			sppr_pkg::REG_MAP_WIDTH:  cur_w = int'(d[7:0]);
			sppr_pkg::REG_MAP_HEIGHT: cur_h = int'(d[7:0]);
			sppr_pkg::REG_TOLERANCE:  cur_tol = int'(d);
			sppr_pkg::REG_BYPASS:     cur_byp = d[0];
		endcase
	endtask

	task automatic run_phase(int p, bit [15:0] w, bit [15:0] h, bit [15:0] tol,
			bit [15:0] byp, int budget, bit pause);
		drain();
		write_reg(sppr_pkg::REG_MAP_WIDTH, w);
		write_reg(sppr_pkg::REG_MAP_HEIGHT, h);
		write_reg(sppr_pkg::REG_TOLERANCE, tol);
		write_reg(sppr_pkg::REG_BYPASS, byp);
		case (p % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
			default: begin send_idle_pct = 7; recv_stall_pct = 7; end
		endcase
		if (pause) begin
			add_random_traffic(budget / 2);
			drain();
			add_random_traffic(budget / 2);
		end else begin
			add_random_traffic(budget);
		end
	endtask

	// driver
	always @(negedge clk) begin
		bit nv;
		if (in_taken)
			void'(pending_items.pop_front());
		if (!arst_n)
			nv = 0;
		else if (in_ch.valid && !in_taken)
			nv = 1;
		else
			nv = pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct;
		in_ch.valid <= nv;
		if (nv) begin
			in_ch.func   <= pending_items[0].func;
			in_ch.col    <= pending_items[0].col;
			in_ch.row    <= pending_items[0].row;
			in_ch.sample <= pending_items[0].sample;
		end
	end

	always @(negedge clk)
		out_ch.ready <= arst_n && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		peak_t e;
		cycles++;
		in_taken = arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (peak_exp_q.size() == 0) begin
				report_mismatch("unexpected transaction, status", out_ch.status, -1);
			end else begin
				e = peak_exp_q.pop_front();
				if (out_ch.peak_x !== e.x)
					report_mismatch("peak_x", out_ch.peak_x, e.x);
				if (out_ch.peak_y !== e.y)
					report_mismatch("peak_y", out_ch.peak_y, e.y);
				if (out_ch.status !== e.st)
					report_mismatch("status", out_ch.status, e.st);
			end
		end
		if (cycles > CYCLE_MAX) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = sppr_pkg::REG_MAP_WIDTH;
		cfg_ch.data = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, sample extremes, edges, flat and clipped fits
		add_load(0, 0, 32'h8000_0000);
		add_load(127, 127, 32'h7FFF_FFFF);
		add_load(1, 0, 32'h0000_0000);
		add_query(0, 0);
		add_query(127, 127);
		add_load(40, 40, 1000);
		add_load(39, 40, 6000);
		add_load(41, 40, -4000);
		add_load(40, 41, 3000);
		add_load(40, 39, 500);
		add_query(40, 40);
		add_load(60, 60, 0);
		add_load(59, 60, -20);
		add_load(61, 60, 10);
		add_load(60, 59, -20);
		add_load(60, 61, 10);
		add_query(60, 60);
		add_random_traffic(30);

		run_phase(1, 16, 16, 0, 0, 60, 0);
		hold_req++;
		add_random_traffic(30);
		run_phase(2, 255, 200, 65535, 0, 70, 1);
		run_phase(3, 1, 1, 7, 0, 40, 0);
		run_phase(4, 0, 128, 300, 0, 50, 0);
		run_phase(5, 100, 50, 1, 1, 50, 0);
		run_phase(6, 128, 128, 1, 0, 80, 0);
		run_phase(7, 15, 127, 20000, 0, 50, 0);
		run_phase(8, 64, 96, 2, 0, 70, 0);

		while (pending_items.size() != 0 || peak_exp_q.size() != 0)
			@(posedge clk);
		repeat (END_GAP) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[filelist.f]
design/sppr_pkg.sv
design/sppr_in_if.sv
design/sppr_out_if.sv
design/sppr_cfg_if.sv
design/sppr_map.sv
design/sppr_div.sv
design/subpixel_peak_parabola_refine.sv
sim/subpixel_peak_parabola_refine_tb.sv
